### src/chebyshev_series_eval_2d_assert.svh
// Assertion macros for the chebyshev_series_eval_2d block (clk / rst in scope)
`ifndef CHEBYSHEV_SERIES_EVAL_2D_ASSERT_SVH
`define CHEBYSHEV_SERIES_EVAL_2D_ASSERT_SVH

// same-cycle implication
`define CSE2D_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cse2d assertion failed");

// next-cycle implication
`define CSE2D_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cse2d assertion failed");

`endif

### src/cse2d_pkg.sv
// Shared types, widths and saturation helpers for the 2D Chebyshev evaluator
package cse2d_pkg;

  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int SAT_W   = 66;
  // c * w >> 16 fits in 48 signed bits
  localparam int TERM_W  = 48;

  localparam logic signed [31:0] T0_VALUE = 32'sd65536;

  localparam logic signed [31:0] X_CENTER_RST = 32'sd327680;
  localparam logic [30:0]        X_IHW_RST    = 31'd13107;
  localparam logic signed [31:0] Y_CENTER_RST = 32'sd327680;
  localparam logic [30:0]        Y_IHW_RST    = 31'd13107;

  typedef enum logic [1:0] {
    REG_X_CENTER = 2'd0,
    REG_X_IHW    = 2'd1,
    REG_Y_CENTER = 2'd2,
    REG_Y_IHW    = 2'd3
  } reg_index_t;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } command_t;

  typedef struct packed {
    logic signed [31:0] x_center;
    logic [30:0]        x_inv_half_width;
    logic signed [31:0] y_center;
    logic [30:0]        y_inv_half_width;
  } cfg_t;

  typedef struct packed {
    command_t           command;
    logic [9:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
  } cmd_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] series_value;
    logic               saturated;
  } res_t;

  localparam logic signed [SAT_W-1:0] SAT_MAX = 66'sh0_7fff_ffff;
  localparam logic signed [SAT_W-1:0] SAT_MIN = -66'sh0_8000_0000;

  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) r = 32'sh7fff_ffff;
    else if (v < SAT_MIN) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic sat32_hit(input logic signed [SAT_W-1:0] v);
    return (v > SAT_MAX) || (v < SAT_MIN);
  endfunction

endpackage

### src/chebyshev_series_eval_2d.sv
// Throughput: one load per cycle while idle. An evaluate holds input off while it runs
//   or while its result word waits.
// Each coefficient passes through S_A (weight product), S_B (clamp) and S_C (coefficient
//   product) around the single shared multiplier; each recurrence step through S_REC and S_RECW.
// Reset: config registers to defaults, control cleared; memories undefined until written.
module chebyshev_series_eval_2d #(
  parameter int DEGREE_X = 22,
  parameter int DEGREE_Y = 22
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [111:0] s_tdata,   // coef_index[9:0], coef_value, x_coord, y_coord, zero pad
  input  logic [0:0]   s_tuser,   // command
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata,   // series_value
  output logic [0:0]   m_tuser,   // saturated
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  cse2d_pkg::cfg_t cfg;
  cse2d_pkg::cmd_t cmd;
  cse2d_pkg::res_t res;
  logic            start;
  logic            out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_center         <= cse2d_pkg::X_CENTER_RST;
      cfg.x_inv_half_width <= cse2d_pkg::X_IHW_RST;
      cfg.y_center         <= cse2d_pkg::Y_CENTER_RST;
      cfg.y_inv_half_width <= cse2d_pkg::Y_IHW_RST;
    end else if (cfg_we) begin
      unique case (cse2d_pkg::reg_index_t'(cfg_index))
        cse2d_pkg::REG_X_CENTER: cfg.x_center         <= cfg_data;
        cse2d_pkg::REG_X_IHW:    cfg.x_inv_half_width <= cfg_data[30:0];
        cse2d_pkg::REG_Y_CENTER: cfg.y_center         <= cfg_data;
        cse2d_pkg::REG_Y_IHW:    cfg.y_inv_half_width <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  assign cmd.command    = cse2d_pkg::command_t'(s_tuser[0]);
  assign cmd.coef_index = s_tdata[9:0];
  assign cmd.coef_value = s_tdata[41:10];
  assign cmd.x_coord    = s_tdata[73:42];
  assign cmd.y_coord    = s_tdata[105:74];

  assign start    = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  cse2d_core #(
    .DEGREE_X (DEGREE_X),
    .DEGREE_Y (DEGREE_Y)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .start    (start),
    .ready    (s_tready),
    .out_free (out_free),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (res.valid) begin
        m_tvalid <= 1'b1;
        m_tdata  <= res.series_value;
        m_tuser  <= res.saturated;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

`include "chebyshev_series_eval_2d_assert.svh"

  `CSE2D_ASSERT_NEXT(a_eval_busy, s_tvalid && s_tready && cmd.command == cse2d_pkg::CMD_EVAL, !s_tready)
  `CSE2D_ASSERT_IMPL(a_result_slot_free, res.valid, !m_tvalid || m_tready)
  `CSE2D_ASSERT_IMPL(a_sat_on_rail, m_tvalid && m_tuser[0],
    m_tdata == 32'h7fff_ffff || m_tdata == 32'h8000_0000)

endmodule

### src/cse2d_mul.sv
// Shared signed 33x32 multiplier with registered product
module cse2d_mul (
  input  logic                                  clk,
  input  logic signed [cse2d_pkg::MUL_A_W-1:0]  a,
  input  logic signed [cse2d_pkg::MUL_B_W-1:0]  b,
  output logic signed [cse2d_pkg::MUL_P_W-1:0]  p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

### src/cse2d_core.sv
// Sequencer, coefficient and basis memories, accumulator around the shared multiplier
module cse2d_core #(
  parameter int DEGREE_X = 22,
  parameter int DEGREE_Y = 22
) (
  input  logic              clk,
  input  logic              rst,
  input  cse2d_pkg::cfg_t   cfg,
  input  cse2d_pkg::cmd_t   cmd,
  input  logic              start,
  output logic              ready,
  input  logic              out_free,
  output cse2d_pkg::res_t   res
);

  localparam int NX         = DEGREE_X + 1;
  localparam int NY         = DEGREE_Y + 1;
  localparam int TABLE_SIZE = NX * NY;
  localparam int XA_W       = $clog2(NX);
  localparam int YA_W       = $clog2(NY);
  localparam int TA_W       = $clog2(TABLE_SIZE);
  localparam int DMAX       = (DEGREE_X > DEGREE_Y) ? DEGREE_X : DEGREE_Y;
  localparam int KW         = $clog2(DMAX + 1);
  localparam int ACC_W      = cse2d_pkg::TERM_W + TA_W;

  typedef enum logic [3:0] {
    S_IDLE, S_MAP, S_MAPW, S_REC, S_RECW, S_PREP, S_FILL,
    S_A, S_B, S_C, S_LAST, S_DONE
  } state_t;

  state_t state;

  logic                sel;        // 0: x axis, 1: y axis
  logic [KW-1:0]       k;
  logic signed [31:0]  u_reg, tk, tkm1;
  logic signed [31:0]  xcoord, ycoord;
  logic [XA_W-1:0]     i;
  logic [YA_W-1:0]     j;
  logic [TA_W-1:0]     caddr;
  logic signed [31:0]  xb_q, yb_q, cq, w;
  logic                zi, zj, last, have_prev;
  logic signed [ACC_W-1:0] acc;

  logic signed [31:0]  cmem [TABLE_SIZE];
  logic signed [31:0]  xmem [NX];
  logic signed [31:0]  ymem [NY];

  logic signed [cse2d_pkg::MUL_A_W-1:0] mul_a;
  logic signed [cse2d_pkg::MUL_B_W-1:0] mul_b;
  logic signed [cse2d_pkg::MUL_P_W-1:0] p;
  logic signed [cse2d_pkg::MUL_P_W-1:0] p_sh;
  logic signed [ACC_W-1:0]              term;
  logic signed [31:0]                   u_new, t_new, w_new, b_wdata;
  logic [KW-1:0]                        k_inc, deg;
  logic [KW-1:0]                        b_waddr;
  logic                                 b_we;
  logic                                 c_we;

  cse2d_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (p)
  );

  assign k_inc = k + 1'b1;
  assign deg   = sel ? KW'(DEGREE_Y) : KW'(DEGREE_X);
  assign u_new = cse2d_pkg::sat32(cse2d_pkg::SAT_W'(p >>> 16));
  assign t_new = cse2d_pkg::sat32(cse2d_pkg::SAT_W'(p >>> 15) - cse2d_pkg::SAT_W'(tkm1));
  assign w_new = cse2d_pkg::sat32(cse2d_pkg::SAT_W'(p >>> 16));

  // index-zero terms are halved once per zero index
  always_comb begin
    priority if (zi && zj) p_sh = p >>> 18;
    else if (zi || zj)     p_sh = p >>> 17;
    else                   p_sh = p >>> 16;
  end
  assign term = ACC_W'(p_sh);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_MAP: begin
        mul_a = sel ? ({ycoord[31], ycoord} - {cfg.y_center[31], cfg.y_center})
                    : ({xcoord[31], xcoord} - {cfg.x_center[31], cfg.x_center});
        mul_b = sel ? {1'b0, cfg.y_inv_half_width} : {1'b0, cfg.x_inv_half_width};
      end
      S_REC: begin
        mul_a = {u_reg[31], u_reg};
        mul_b = tk;
      end
      S_A: begin
        mul_a = {xb_q[31], xb_q};
        mul_b = yb_q;
      end
      S_C: begin
        mul_a = {cq[31], cq};
        mul_b = w;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // basis write port
  always_comb begin
    b_we    = 1'b0;
    b_waddr = k_inc;
    b_wdata = t_new;
    unique case (state)
      S_MAP: begin
        b_we    = 1'b1;
        b_waddr = k;
        b_wdata = cse2d_pkg::T0_VALUE;
      end
      S_MAPW: begin
        b_we    = 1'b1;
        b_wdata = u_new;
      end
      S_RECW: begin
        b_we    = 1'b1;
      end
      default: b_we = 1'b0;
    endcase
  end

  assign c_we = start && (cmd.command == cse2d_pkg::CMD_LOAD) &&
                (int'(cmd.coef_index) < TABLE_SIZE);

  always_ff @(posedge clk) begin
    if (c_we) cmem[TA_W'(cmd.coef_index)] <= cmd.coef_value;
    cq <= cmem[caddr];
  end

  always_ff @(posedge clk) begin
    if (b_we && !sel) xmem[XA_W'(b_waddr)] <= b_wdata;
    xb_q <= xmem[i];
  end

  always_ff @(posedge clk) begin
    if (b_we && sel) ymem[YA_W'(b_waddr)] <= b_wdata;
    yb_q <= ymem[j];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sel       <= 1'b0;
      k         <= '0;
      i         <= '0;
      j         <= '0;
      caddr     <= '0;
      have_prev <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start && cmd.command == cse2d_pkg::CMD_EVAL) begin
            xcoord <= cmd.x_coord;
            ycoord <= cmd.y_coord;
            sel    <= 1'b0;
            k      <= '0;
            state  <= S_MAP;
          end
        end
        S_MAP: state <= S_MAPW;
        S_MAPW: begin
          u_reg <= u_new;
          tk    <= u_new;
          tkm1  <= cse2d_pkg::T0_VALUE;
          if (k_inc == deg) begin
            if (!sel) begin
              sel   <= 1'b1;
              k     <= '0;
              state <= S_MAP;
            end else begin
              k     <= k_inc;
              state <= S_PREP;
            end
          end else begin
            k     <= k_inc;
            state <= S_REC;
          end
        end
        S_REC: state <= S_RECW;
        S_RECW: begin
          tkm1 <= tk;
          tk   <= t_new;
          if (k_inc == deg) begin
            if (!sel) begin
              sel   <= 1'b1;
              k     <= '0;
              state <= S_MAP;
            end else begin
              k     <= k_inc;
              state <= S_PREP;
            end
          end else begin
            k     <= k_inc;
            state <= S_REC;
          end
        end
        S_PREP: begin
          i         <= '0;
          j         <= '0;
          caddr     <= '0;
          acc       <= '0;
          have_prev <= 1'b0;
          state     <= S_FILL;
        end
        S_FILL: state <= S_A;
        S_A: begin
          if (have_prev) acc <= acc + term;
          have_prev <= 1'b1;
          state     <= S_B;
        end
        S_B: begin
          w    <= w_new;
          zi   <= (i == '0);
          zj   <= (j == '0);
          last <= (caddr == TA_W'(TABLE_SIZE - 1));
          // step to next coefficient; reads for it land before the next S_A
          caddr <= caddr + 1'b1;
          if (i == XA_W'(DEGREE_X)) begin
            i <= '0;
            j <= j + 1'b1;
          end else begin
            i <= i + 1'b1;
          end
          state <= S_C;
        end
        S_C: state <= last ? S_LAST : S_A;
        S_LAST: begin
          acc   <= acc + term;
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign ready            = (state == S_IDLE);
  assign res.valid        = (state == S_DONE) && out_free;
  assign res.series_value = cse2d_pkg::sat32(cse2d_pkg::SAT_W'(acc));
  assign res.saturated    = cse2d_pkg::sat32_hit(cse2d_pkg::SAT_W'(acc));

endmodule

### bench/chebyshev_series_eval_2d_tb.sv
// Self-checking testbench for the 2D Chebyshev series evaluator
`timescale 1ns / 100ps

module chebyshev_series_eval_2d_tb;

  localparam int DEG_X = 22;
  localparam int DEG_Y = 22;
  localparam int CELLS = (DEG_X + 1) * (DEG_Y + 1);
  localparam int QUIET_LIMIT = 8000;
  localparam int WORDS_PER_PHASE = 104;
  localparam int PHASES = 5;
  localparam longint TOP = 64'sd2147483647;
  localparam longint BOT = -64'sd2147483648;

  typedef struct {
    logic signed [31:0] value;
    logic               sat;
  } sum_t;

  // Holds the table and register copies, predicts each series sum, checks results
  class series_checker;
    longint x_mid, x_scale, y_mid, y_scale;
    int     coef[CELLS];
    sum_t   expected_sums[$];
    int     errors;

    function new();
      x_mid   = longint'(cse2d_pkg::X_CENTER_RST);
      x_scale = longint'(cse2d_pkg::X_IHW_RST);
      y_mid   = longint'(cse2d_pkg::Y_CENTER_RST);
      y_scale = longint'(cse2d_pkg::Y_IHW_RST);
      errors  = 0;
    endfunction

    static function longint clamp32(longint v);
      if (v > TOP) return TOP;
      if (v < BOT) return BOT;
      return v;
    endfunction

    task flag(string msg);
      errors++;
      $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    function void set_reg(cse2d_pkg::reg_index_t r, logic [31:0] d);
      case (r)
        cse2d_pkg::REG_X_CENTER: x_mid   = longint'($signed(d));
        cse2d_pkg::REG_X_IHW:    x_scale = longint'(d[30:0]);
        cse2d_pkg::REG_Y_CENTER: y_mid   = longint'($signed(d));
        cse2d_pkg::REG_Y_IHW:    y_scale = longint'(d[30:0]);
        default: ;
      endcase
    endfunction

    // T0..Tdeg of the mapped coordinate, floor shifts, clamped to 32 bits
    function void chebyshev_row(longint coord, longint mid, longint scale, int deg,
                                output longint t[0:63]);
      longint u;
      int k;
      u = clamp32(((coord - mid) * scale) >>> 16);
      t[0] = 65536;
      t[1] = u;
      for (k = 1; k < deg; k++)
        t[k + 1] = clamp32(((u * t[k]) >>> 15) - t[k - 1]);
    endfunction

    function sum_t series_at(longint xc, longint yc);
      longint tx[0:63];
      longint ty[0:63];
      longint w, acc;
      int i, j;
      sum_t r;
      chebyshev_row(xc, x_mid, x_scale, DEG_X, tx);
      chebyshev_row(yc, y_mid, y_scale, DEG_Y, ty);
      acc = 0;
      for (j = 0; j <= DEG_Y; j++) begin
        for (i = 0; i <= DEG_X; i++) begin
          w = clamp32((tx[i] * ty[j]) >>> 16);
          // index-zero terms are halved once per zero index
          acc += (longint'(coef[i + (DEG_X + 1) * j]) * w) >>> (16 + (i == 0) + (j == 0));
        end
      end
      r.sat   = (acc > TOP) || (acc < BOT);
      r.value = 32'(clamp32(acc));
      return r;
    endfunction

    function void note_word(cse2d_pkg::command_t cmd, logic [9:0] idx, logic [31:0] val,
                            logic [31:0] xv, logic [31:0] yv);
      if (cmd == cse2d_pkg::CMD_LOAD) begin
        if (idx < CELLS) coef[idx] = $signed(val);
      end else begin
        expected_sums.push_back(series_at(longint'($signed(xv)), longint'($signed(yv))));
      end
    endfunction

    task check_word(logic [31:0] got_value, logic got_sat);
      sum_t want;
      if (expected_sums.size() == 0) begin
        flag($sformatf("result %h sat %b with no evaluate pending", got_value, got_sat));
        return;
      end
      want = expected_sums.pop_front();
      if (got_value !== want.value)
        flag($sformatf("series_value got %h want %h", got_value, want.value));
      if (got_sat !== want.sat)
        flag($sformatf("saturated got %b want %b (value %h)", got_sat, want.sat, want.value));
    endtask
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [111:0] s_tdata = '0;
  logic [0:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [31:0]  m_tdata;
  logic [0:0]   m_tuser;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  series_checker sb = new();
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;
  int quiet = 0;

  chebyshev_series_eval_2d #(
    .DEGREE_X(DEG_X),
    .DEGREE_Y(DEG_Y)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // nothing accepted for too long means a lost or stuck word
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet + 1 >= QUIET_LIMIT) begin
        sb.flag($sformatf("no handshake for %0d cycles, %0d sums outstanding",
                          QUIET_LIMIT, sb.expected_sums.size()));
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // result side: random stall before each word, with calm stretches
  initial begin
    int stall;
    wait (!rst);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
      stall = out_calm ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_word(m_tdata, m_tuser[0]);
      @(negedge clk);
    end
  end

  task automatic send_word(cse2d_pkg::command_t cmd, logic [9:0] idx, logic [31:0] val,
                           logic [31:0] xv, logic [31:0] yv);
    int gap;
    if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, yv, xv, val, idx};
    s_tuser  <= cmd;
    do @(posedge clk); while (!s_tready);
    sb.note_word(cmd, idx, val, xv, yv);
    @(negedge clk);
  endtask

  // wait for every pending sum, then let trailing loads retire
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.expected_sums.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(cse2d_pkg::reg_index_t r, logic [31:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= d;
    sb.set_reg(r, d);
    @(negedge clk);
  endtask

  // bit 31 of the width registers is don't-care, so toggle it
  task automatic write_regs(logic [31:0] xc, logic [30:0] xi, logic [31:0] yc, logic [30:0] yi);
    write_reg(cse2d_pkg::REG_X_CENTER, xc);
    write_reg(cse2d_pkg::REG_X_IHW, {1'($urandom_range(0, 1)), xi});
    write_reg(cse2d_pkg::REG_Y_CENTER, yc);
    write_reg(cse2d_pkg::REG_Y_IHW, {1'($urandom_range(0, 1)), yi});
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_coef();
    case ($urandom_range(0, 15))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom) >>> $urandom_range(8, 24));
    endcase
  endfunction

  // point whose mapped coordinate lands in [-1, 1]
  function automatic logic [31:0] near_point(longint mid, longint scale);
    longint p;
    if (scale == 0)
      p = mid + longint'($urandom_range(0, 131072)) - 64'sd65536;
    else
      p = mid + ((longint'($urandom_range(0, 131072)) - 64'sd65536) * 64'sd65536) / scale;
    return 32'(sb.clamp32(p));
  endfunction

  task automatic random_word();
    logic [9:0]  idx;
    logic [31:0] xv, yv;
    if ($urandom_range(0, 9) < 7) begin
      if ($urandom_range(0, 15) == 0) idx = 10'($urandom_range(CELLS, 1023));
      else idx = 10'($urandom_range(0, CELLS - 1));
      send_word(cse2d_pkg::CMD_LOAD, idx, pick_coef(), $urandom, $urandom);
    end else begin
      if ($urandom_range(0, 3) == 0) begin
        xv = $urandom;
        yv = $urandom;
      end else begin
        xv = near_point(sb.x_mid, sb.x_scale);
        yv = near_point(sb.y_mid, sb.y_scale);
      end
      send_word(cse2d_pkg::CMD_EVAL, 10'($urandom), $urandom, xv, yv);
    end
  endtask

  initial begin
    int i, p;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // whole table first, so no evaluate ever reads an unwritten entry
    for (i = 0; i < CELLS; i++)
      send_word(cse2d_pkg::CMD_LOAD, 10'(i), 32'($signed($urandom) >>> $urandom_range(12, 24)),
                $urandom, $urandom);

    // coefficient extremes, a zero coefficient and loads past the end of the table
    send_word(cse2d_pkg::CMD_LOAD, 10'd0, 32'h7fff_ffff, $urandom, $urandom);
    send_word(cse2d_pkg::CMD_LOAD, 10'(CELLS - 1), 32'h8000_0000, $urandom, $urandom);
    send_word(cse2d_pkg::CMD_LOAD, 10'(CELLS), $urandom, $urandom, $urandom);
    send_word(cse2d_pkg::CMD_LOAD, 10'h3ff, $urandom, $urandom, $urandom);
    send_word(cse2d_pkg::CMD_LOAD, 10'd22, 32'h0, $urandom, $urandom);
    // center, domain edges, coordinate extremes (mapped value clamps)
    send_word(cse2d_pkg::CMD_EVAL, 10'($urandom), $urandom, 32'sd327680, 32'sd327680);
    send_word(cse2d_pkg::CMD_EVAL, 10'($urandom), $urandom, 32'sd655360, 32'sd0);
    send_word(cse2d_pkg::CMD_EVAL, 10'($urandom), $urandom, 32'sd0, 32'sd655360);
    send_word(cse2d_pkg::CMD_EVAL, 10'($urandom), $urandom, 32'h7fff_ffff, 32'h8000_0000);
    send_word(cse2d_pkg::CMD_EVAL, 10'($urandom), $urandom, 32'h8000_0000, 32'h7fff_ffff);
    send_word(cse2d_pkg::CMD_EVAL, 10'($urandom), $urandom, 32'h7fff_ffff, 32'h7fff_ffff);
    send_word(cse2d_pkg::CMD_EVAL, 10'($urandom), $urandom, 32'h0, 32'h0);
    send_word(cse2d_pkg::CMD_EVAL, 10'($urandom), $urandom, $urandom, $urandom);

    for (p = 0; p < PHASES; p++) begin
      if (p > 0) settle();
      case (p)
        1: write_regs(32'h0, 31'd65536, -32'sd196608, 31'd32768);
        2: write_regs(32'h8000_0000, 31'h7fff_ffff, 32'h7fff_ffff, 31'd0);
        3: write_regs(32'h7fff_ffff, 31'd0, 32'h8000_0000, 31'h7fff_ffff);
        4: write_regs($urandom, 31'($urandom_range(1, 1 << 18)),
                      $urandom, 31'($urandom_range(1, 1 << 18)));
        default: ;
      endcase
      for (i = 0; i < WORDS_PER_PHASE; i++) random_word();
    end

    settle();
    repeat (40) @(negedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
